FILE: sv/pli_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; imported by pli_cell, positional_list_insert_delete and its testbench.
package pli_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;  // insert accepted: shift right behind idx, load at idx
    logic             del;  // delete accepted: shift left from idx on
    logic [PosW-1:0]  idx;  // 0-based list index
    logic [DataW-1:0] val;  // word to load on insert
  } cmd_t;

endpackage

FILE: sv/pli_cell.sv
// One storage cell of the list row: holds one word and decides locally
// whether to hold, load, take its left or take its right neighbor.
// Depends on pli_pkg.
module pli_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                      clk_i,
  input  pli_pkg::cmd_t             cmd_i,
  input  logic [pli_pkg::DataW-1:0] left_i,
  input  logic [pli_pkg::DataW-1:0] right_i,
  output logic [pli_pkg::DataW-1:0] data_o,
  output logic [pli_pkg::DataW-1:0] hit_o
);
  import pli_pkg::*;

  localparam logic [31:0] MyIdx = 32'(INDEX);

  logic [31:0]      idx_ext;
  logic [DataW-1:0] word_d, word_q;

  assign idx_ext = 32'(cmd_i.idx);

  // Pick the next word from the broadcast command and own place
  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (MyIdx > idx_ext) begin
        word_d = left_i;
      end else if (MyIdx == idx_ext) begin
        word_d = cmd_i.val;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= idx_ext) begin
        word_d = right_i;
      end
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign data_o = word_q;
  // Drive the read bus only when addressed
  assign hit_o  = (MyIdx == idx_ext) ? word_q : '0;

endmodule

FILE: sv/positional_list_insert_delete.sv
// Top level of the positional list: count register, request checks and
// the row of pli_cell storage cells. Depends on pli_pkg and pli_cell.
//
// Usage:
//   Command channel: drive operation_i, position_i and value_i and raise
//   start_i; the word is taken at a rising edge where start_i is high and
//   busy_o is low. busy_o stays low, so a new word may be issued in every
//   cycle.
//   Result channel: done_o pulses for one cycle, in the cycle after the
//   command edge, carrying status_o, element_count_o and read_value_o.
//   Throughput is 1 word per cycle: every cell updates in
//   the same edge from its neighbors, and the addressed word is picked by
//   one OR tree over the row before the result register.
//   The receiver cannot stall; a result not taken in its cycle is lost.
//   Positions are 1-based; an insert goes before the element now at that
//   position. Rejected requests leave the list unchanged and return zero.
//   Reset clears the count and the result strobe; cell contents are not
//   cleared and only positions up to the count are ever read.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = pli_pkg::DefaultCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        operation_i,
  input  logic [pli_pkg::PosW-1:0]          position_i,
  input  logic signed [pli_pkg::DataW-1:0]  value_i,
  output logic                              done_o,
  output logic [pli_pkg::StatW-1:0]         status_o,
  output logic [pli_pkg::CountW-1:0]        element_count_o,
  output logic signed [pli_pkg::DataW-1:0]  read_value_o
);
  import pli_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CmpW-1:0] CapCmp = CmpW'(CAPACITY);

  logic            accept;
  logic [CmpW-1:0] pos_c, cnt_c;
  logic            pos_nz, in_list, ins_range;
  logic            ins_ok, del_ok, rd_ok;
  cmd_t            cmd;

  logic [CntW-1:0]  count_d, count_q;
  status_e          status_d;
  logic [DataW-1:0] pick;
  logic             done_d, done_q;
  logic [StatW-1:0] status_q;
  logic [CountW-1:0] count_out_q;
  logic [DataW-1:0] rd_d, rd_q;

  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] cell_hit  [CAPACITY];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Check the requested position against the current count
  assign pos_c     = CmpW'(position_i);
  assign cnt_c     = CmpW'(count_q);
  assign pos_nz    = (position_i != '0);
  assign in_list   = pos_nz && (pos_c <= cnt_c);
  assign ins_range = pos_nz && (pos_c <= cnt_c + CmpW'(1));

  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    rd_ok    = 1'b0;
    status_d = ST_BAD_POS;
    case (op_e'(operation_i))
      OP_INSERT: begin
        if (ins_range) begin
          if (cnt_c >= CapCmp) begin
            status_d = ST_FULL;
          end else begin
            ins_ok   = accept;
            status_d = ST_DONE;
          end
        end
      end
      OP_DELETE: begin
        if (in_list) begin
          del_ok   = accept;
          rd_ok    = 1'b1;
          status_d = ST_DONE;
        end
      end
      OP_READ: begin
        if (in_list) begin
          rd_ok    = 1'b1;
          status_d = ST_DONE;
        end
      end
      default: begin
        status_d = ST_BAD_POS;
      end
    endcase
  end

  // Broadcast the command to the row
  assign cmd.ins = ins_ok;
  assign cmd.del = del_ok;
  assign cmd.idx = position_i - PosW'(1);
  assign cmd.val = value_i;

  // Row of storage cells, each linked to both neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end
    pli_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .hit_o   (cell_hit[g])
    );
  end

  // Merge the addressed word from the row
  always_comb begin
    pick = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      pick = pick | cell_hit[k];
    end
  end

  // Advance the count
  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign done_d = accept;
  assign rd_d   = rd_ok ? pick : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      count_out_q <= CountW'(count_d);
      rd_q        <= rd_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign element_count_o = count_out_q;
  assign read_value_o    = rd_q;

  // Count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("list count above capacity");

  // Every accepted command gives a result strobe in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after command");

  // A failed request returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> read_value_o == '0)
    else $error("nonzero value on failed request");

  // Count changes only on a valid insert or delete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_ok || del_ok) |=> $stable(count_q))
    else $error("count changed without a valid insert or delete");

endmodule

FILE: dv/positional_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_insert_delete: directed and random list words,
// checked against an in-bench model of the list. Depends on pli_pkg and the block's RTL.
module positional_list_insert_delete_tb;
  import pli_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam logic [1:0]  OpUnused = 2'd3;
  localparam logic signed [DataW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] ValMin = 32'sh8000_0000;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       count;
    logic signed [DataW-1:0] value;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [1:0]               operation_i;
  logic [PosW-1:0]          position_i;
  logic signed [DataW-1:0]  value_i;
  logic                     done_o;
  logic [StatW-1:0]         status_o;
  logic [CountW-1:0]        element_count_o;
  logic signed [DataW-1:0]  read_value_o;

  // Model of the list contents and its fill level
  logic signed [DataW-1:0]  list_words [Capacity];
  int                       list_count;
  list_result_t             pending_results [$];

  bit idle_enable;
  int words_sent;
  int results_checked;
  int failures;
  int peak_count;
  int status_seen [4];

  positional_list_insert_delete #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .element_count_o(element_count_o),
    .read_value_o   (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one word to the list model and return the result it should produce
  function automatic list_result_t apply_list_word(input logic [1:0] op,
                                                   input logic [PosW-1:0] pos,
                                                   input logic signed [DataW-1:0] val);
    list_result_t res;
    int p;
    p = int'(pos);
    res.status = ST_BAD_POS;
    res.value  = '0;
    if (op == OP_INSERT) begin
      if (p >= 1 && p <= list_count + 1) begin
        if (list_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_count; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = val;
          list_count++;
          res.status = ST_DONE;
        end
      end
    end else if (op == OP_DELETE) begin
      if (p >= 1 && p <= list_count) begin
        res.value = list_words[p-1];
        for (int i = p; i < list_count; i++) list_words[i-1] = list_words[i];
        list_count--;
        res.status = ST_DONE;
      end
    end else if (op == OP_READ) begin
      if (p >= 1 && p <= list_count) begin
        res.value  = list_words[p-1];
        res.status = ST_DONE;
      end
    end
    res.count = list_count[CountW-1:0];
    return res;
  endfunction

  // Issue one word, after a random gap when idle_enable is set, and record what it should return
  task automatic send_word(input logic [1:0] op, input logic [PosW-1:0] pos,
                           input logic signed [DataW-1:0] val);
    int gap;
    gap = idle_enable ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_list_word(op, pos, val));
    words_sent++;
    if (list_count > peak_count) peak_count = list_count;
  endtask

  // Compare every strobed result with the oldest pending one
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d count %0d value %0d",
               status_o, element_count_o, read_value_o);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        status_seen[status_o]++;
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          failures++;
        end
        if (element_count_o !== exp_res.count) begin
          $error("element_count: expected %0d, got %0d", exp_res.count, element_count_o);
          failures++;
        end
        if (read_value_o !== exp_res.value) begin
          $error("read_value: expected %0d, got %0d", exp_res.value, read_value_o);
          failures++;
        end
      end
    end
  end

  // Draw a data word, leaning on the extremes now and then
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ValMax;
      1:       return ValMin;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal positions for the operation, sometimes anything the field holds
  function automatic logic [PosW-1:0] pick_position(input logic [1:0] op);
    if ($urandom_range(0, 9) == 0) return PosW'($urandom_range(0, 31));
    if (op == OP_INSERT) return PosW'($urandom_range(1, list_count + 1));
    if (list_count == 0) return PosW'($urandom_range(0, 31));
    return PosW'($urandom_range(1, list_count));
  endfunction

  task automatic run_random_mix(input int n_words, input int ins_pct, input int del_pct);
    int r;
    logic [1:0] op;
    for (int n = 0; n < n_words; n++) begin
      // alternate stretches of back-to-back words with stretches of random gaps
      idle_enable = ((n / 40) % 3) != 0;
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else if (r < 98) op = OP_READ;
      else op = OpUnused;
      send_word(op, pick_position(op), pick_value());
    end
  endtask

  // Requests on an empty list: all rejected, count stays zero
  task automatic test_empty_list();
    send_word(OP_READ, 5'd1, 32'sd5);
    send_word(OP_DELETE, 5'd1, 32'sd0);
    send_word(OP_INSERT, 5'd0, 32'sd7);
    send_word(OP_INSERT, 5'd2, 32'sd7);
    send_word(OpUnused, 5'd1, ValMax);
  endtask

  // Front, back and next-to-last inserts with extreme data, then reads and deletes
  task automatic test_edge_values();
    send_word(OP_INSERT, 5'd1, ValMax);
    send_word(OP_INSERT, 5'd2, ValMin);
    send_word(OP_INSERT, 5'd2, '1);
    send_word(OP_INSERT, 5'd1, '0);
    for (int p = 1; p <= 5; p++) send_word(OP_READ, p[PosW-1:0], $urandom());
    send_word(OP_READ, 5'd31, 32'sd0);
    send_word(OpUnused, 5'd2, ValMin);
    send_word(OP_INSERT, 5'd31, ValMax);
    send_word(OP_DELETE, 5'd4, 32'sd0);
    send_word(OP_DELETE, 5'd1, 32'sd0);
    send_word(OP_DELETE, 5'd0, 32'sd0);
    send_word(OP_DELETE, 5'd3, 32'sd0);
  endtask

  // Fill to capacity, then probe the full and bad-position rejections
  task automatic test_full_list();
    while (list_count < Capacity)
      send_word(OP_INSERT, PosW'($urandom_range(1, list_count + 1)), pick_value());
    send_word(OP_INSERT, 5'd17, ValMax);
    send_word(OP_INSERT, 5'd18, ValMax);
    send_word(OP_INSERT, 5'd1, ValMin);
    send_word(OP_READ, 5'd16, 32'sd0);
    send_word(OP_READ, 5'd17, 32'sd0);
    send_word(OP_DELETE, 5'd16, 32'sd0);
    send_word(OP_INSERT, 5'd16, pick_value());
  endtask

  task automatic test_insert_heavy();
    run_random_mix(260, 60, 20);
  endtask

  task automatic test_delete_heavy();
    run_random_mix(260, 20, 60);
  endtask

  task automatic test_balanced_mix();
    run_random_mix(260, 40, 40);
  endtask

  initial begin
    int waited;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = OP_READ;
    position_i  = '0;
    value_i     = '0;
    idle_enable = 1'b1;
    list_count  = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_insert_heavy();
    test_delete_heavy();
    test_balanced_mix();

    // Drop start and drain the outstanding results
    @(negedge clk_i);
    start_i <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 50) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failures += pending_results.size();
    end

    $display("Issued %0d words, checked %0d results; peak fill %0d of %0d.",
             words_sent, results_checked, peak_count, Capacity);
    $display("Status counts: done %0d, bad position %0d, full %0d.",
             status_seen[ST_DONE], status_seen[ST_BAD_POS], status_seen[ST_FULL]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
sv/pli_pkg.sv
sv/pli_cell.sv
sv/positional_list_insert_delete.sv
dv/positional_list_insert_delete_tb.sv
